// File: sv/word_alu_with_overflow_skip_defines.svh
// Assertion macros shared by the checker of the word ALU.
`ifndef WORD_ALU_WITH_OVERFLOW_SKIP_DEFINES_SVH
`define WORD_ALU_WITH_OVERFLOW_SKIP_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and quiet while rst_ni is low.
`define WALU_ASSERT_IMPL(name_, ante_, cons_) \
  name_: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante_) |-> (cons_)) \
    else $error("same-cycle check failed");

// Next-cycle implication, sampled on clk_i and quiet while rst_ni is low.
`define WALU_ASSERT_NEXT(name_, ante_, cons_) \
  name_: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante_) |=> (cons_)) \
    else $error("next-cycle check failed");

`endif

// File: sv/walu_pkg.sv
// Package of the word ALU: beat types, opcodes, divider constants and control structs.
`default_nettype none

package walu_pkg;

  // Opcodes of the action field.
  localparam logic [3:0] OP_NONBASIC = 4'd0;
  localparam logic [3:0] OP_SET      = 4'd1;
  localparam logic [3:0] OP_ADD      = 4'd2;
  localparam logic [3:0] OP_SUB      = 4'd3;
  localparam logic [3:0] OP_MUL      = 4'd4;
  localparam logic [3:0] OP_DIV      = 4'd5;
  localparam logic [3:0] OP_MOD      = 4'd6;
  localparam logic [3:0] OP_SHL      = 4'd7;
  localparam logic [3:0] OP_SHR      = 4'd8;
  localparam logic [3:0] OP_AND      = 4'd9;
  localparam logic [3:0] OP_OR       = 4'd10;
  localparam logic [3:0] OP_XOR      = 4'd11;
  localparam logic [3:0] OP_IFE      = 4'd12;
  localparam logic [3:0] OP_IFN      = 4'd13;
  localparam logic [3:0] OP_IFG      = 4'd14;
  localparam logic [3:0] OP_IFB      = 4'd15;

  // The divider retires two quotient bits per cycle. A divide needs all 32
  // bits of the quotient of {a, 16'h0} / b; a modulo needs only the first 16.
  localparam int DIV_CYCLES = 16;
  localparam int MOD_CYCLES = 8;
  localparam int CNT_W      = $clog2(DIV_CYCLES);

  typedef struct packed {
    logic [3:0]  action;
    logic [15:0] a_value;
    logic [15:0] b_value;
    logic [15:0] next_instruction;
  } in_beat_t;

  typedef struct packed {
    logic [15:0] a_result;
    logic        write_a;
    logic [15:0] overflow_out;
    logic [1:0]  skip_words;
  } out_beat_t;

  typedef struct packed {
    logic accept;
    logic step;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic div_needed;
    logic is_mod;
  } dp_status_t;

endpackage

`default_nettype wire

// File: sv/walu_ctrl.sv
// Controller of the word ALU: handshakes, divider sequencing and output valid.
`default_nettype none

module walu_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  walu_pkg::dp_status_t status_i,
  output walu_pkg::dp_cmd_t    cmd_o
);
  import walu_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DIV  = 1'b1;

  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_CYCLES - 1);
  localparam logic [CNT_W-1:0] MOD_LAST = CNT_W'(MOD_CYCLES - 1);

  logic             state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic             accept;
  logic             last;

  always_comb begin
    in_ready_o = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
    accept     = in_valid_i && in_ready_o;
    last       = status_i.is_mod ? (cnt_q == MOD_LAST) : (cnt_q == DIV_LAST);

    cmd_o.accept = accept;
    cmd_o.step   = (state_q == ST_DIV);
    cmd_o.finish = (state_q == ST_DIV) && last;

    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && status_i.div_needed) begin
          state_d = ST_DIV;
          cnt_d   = '0;
        end
      end
      ST_DIV: begin
        cnt_d = cnt_q + 1'b1;
        if (last) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    out_valid_d = out_valid_q;
    if ((accept && !status_i.div_needed) || cmd_o.finish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// File: sv/walu_dp.sv
// Datapath of the word ALU: combinational ops, radix-4 divider, overflow and output registers.
`default_nettype none

module walu_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  walu_pkg::in_beat_t   in_beat_i,
  input  walu_pkg::dp_cmd_t    cmd_i,
  output walu_pkg::dp_status_t status_o,
  output walu_pkg::out_beat_t  out_beat_o
);
  import walu_pkg::*;

  logic [15:0] ovf_q, ovf_d;
  out_beat_t   out_q, out_d;
  logic [15:0] r_q;
  logic [31:0] q_q;
  logic [15:0] b_q;
  logic        mod_q;

  logic [15:0] a, b;
  out_beat_t   imm;
  logic [16:0] sum;
  logic [31:0] prod;
  logic [31:0] shl_t, shr_t;
  logic        big_shift;
  logic [1:0]  skip_len;
  logic [5:0]  fld_a, fld_b;
  logic        rw_a, rw_b;

  logic [16:0] sh1, sh2, diff1, diff2;
  logic        ge1, ge2;
  logic [15:0] r1, r2;
  logic [31:0] q1, q2;

  assign a = in_beat_i.a_value;
  assign b = in_beat_i.b_value;

  assign status_o.div_needed = ((in_beat_i.action == OP_DIV) || (in_beat_i.action == OP_MOD))
                               && (b != 16'h0);
  assign status_o.is_mod     = mod_q;

  // An operand field reads a next word for 0x10..0x17, 0x1E and 0x1F.
  always_comb begin
    fld_a    = in_beat_i.next_instruction[9:4];
    fld_b    = in_beat_i.next_instruction[15:10];
    rw_a     = (fld_a[5:4] == 2'b01) && (!fld_a[3] || (fld_a[2:1] == 2'b11));
    rw_b     = (fld_b[5:4] == 2'b01) && (!fld_b[3] || (fld_b[2:1] == 2'b11));
    skip_len = 2'd1 + {1'b0, rw_a} + {1'b0, rw_b};
  end

  always_comb begin
    sum       = {1'b0, a} + {1'b0, b};
    prod      = a * b;
    big_shift = (b[15:5] != 11'h0);
    shl_t     = big_shift ? 32'h0 : ({16'h0, a} << b[4:0]);
    shr_t     = big_shift ? 32'h0 : ({a, 16'h0} >> b[4:0]);

    imm.a_result     = a;
    imm.write_a      = 1'b1;
    imm.overflow_out = ovf_q;
    imm.skip_words   = 2'd0;
    unique case (in_beat_i.action)
      OP_SET: imm.a_result = b;
      OP_ADD: begin
        imm.a_result     = sum[15:0];
        imm.overflow_out = {15'h0, sum[16]};
      end
      OP_SUB: begin
        imm.a_result     = a - b;
        imm.overflow_out = (a < b) ? 16'hFFFF : 16'h0;
      end
      OP_MUL: begin
        imm.a_result     = prod[15:0];
        imm.overflow_out = prod[31:16];
      end
      // Only a zero divisor takes this path; other divides run on the divider.
      OP_DIV: begin
        imm.a_result     = 16'h0;
        imm.overflow_out = 16'h0;
      end
      OP_MOD: imm.a_result = 16'h0;
      OP_SHL: begin
        imm.a_result     = shl_t[15:0];
        imm.overflow_out = shl_t[31:16];
      end
      OP_SHR: begin
        imm.a_result     = shr_t[31:16];
        imm.overflow_out = shr_t[15:0];
      end
      OP_AND: imm.a_result = a & b;
      OP_OR:  imm.a_result = a | b;
      OP_XOR: imm.a_result = a ^ b;
      OP_IFE: begin
        imm.write_a    = 1'b0;
        imm.skip_words = (a != b) ? skip_len : 2'd0;
      end
      OP_IFN: begin
        imm.write_a    = 1'b0;
        imm.skip_words = (a == b) ? skip_len : 2'd0;
      end
      OP_IFG: begin
        imm.write_a    = 1'b0;
        imm.skip_words = (a <= b) ? skip_len : 2'd0;
      end
      OP_IFB: begin
        imm.write_a    = 1'b0;
        imm.skip_words = ((a & b) == 16'h0) ? skip_len : 2'd0;
      end
      default: imm.write_a = 1'b0;
    endcase
  end

  // Two restoring division steps per cycle.
  always_comb begin
    sh1   = {r_q, q_q[31]};
    diff1 = sh1 - {1'b0, b_q};
    ge1   = (sh1 >= {1'b0, b_q});
    r1    = ge1 ? diff1[15:0] : sh1[15:0];
    q1    = {q_q[30:0], ge1};

    sh2   = {r1, q1[31]};
    diff2 = sh2 - {1'b0, b_q};
    ge2   = (sh2 >= {1'b0, b_q});
    r2    = ge2 ? diff2[15:0] : sh2[15:0];
    q2    = {q1[30:0], ge2};
  end

  always_comb begin
    out_d = out_q;
    ovf_d = ovf_q;
    if (cmd_i.accept && !status_o.div_needed) begin
      out_d = imm;
      ovf_d = imm.overflow_out;
    end else if (cmd_i.finish) begin
      out_d.write_a    = 1'b1;
      out_d.skip_words = 2'd0;
      if (mod_q) begin
        out_d.a_result     = r2;
        out_d.overflow_out = ovf_q;
      end else begin
        out_d.a_result     = q2[31:16];
        out_d.overflow_out = q2[15:0];
        ovf_d              = q2[15:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovf_q <= 16'h0;
    end else begin
      ovf_q <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (cmd_i.accept) begin
      r_q   <= 16'h0;
      q_q   <= {a, 16'h0};
      b_q   <= b;
      mod_q <= (in_beat_i.action == OP_MOD);
    end else if (cmd_i.step) begin
      r_q <= r2;
      q_q <= q2;
    end
  end

  assign out_beat_o = out_q;

endmodule

`default_nettype wire

// File: sv/word_alu_with_overflow_skip.sv
// Top level of the word ALU: controller and datapath joined by command and status structs.
`default_nettype none

// This block runs one 16-bit basic opcode per input beat and returns one
// output beat carrying the new value of a, its write flag, the overflow
// register after the operation and the number of words to skip. Every opcode
// but a divide or modulo with a nonzero divisor is computed combinationally:
// its beat is shown on the output the cycle after it is accepted. A divide or
// modulo with a nonzero divisor runs on the restoring divider, which retires two
// quotient bits per cycle, and its result is registered into the output when
// the divider finishes. The block holds one operation at a time; a new input
// beat is taken once the divider is idle and the output register is empty or
// being emptied in the same cycle. The overflow register resets to zero and
// carries from one operation to the next.
module word_alu_with_overflow_skip (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  walu_pkg::in_beat_t  in_beat_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output walu_pkg::out_beat_t out_beat_o
);
  import walu_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // The controller owns the handshakes and counts divider cycles.
  walu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // The datapath computes results and holds the overflow and output registers.
  walu_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_beat_i  (in_beat_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_beat_o (out_beat_o)
  );

endmodule

`default_nettype wire

// File: sv/walu_checker.sv
// Port-level checker of the word ALU and its bind to the top level.
`default_nettype none

`include "word_alu_with_overflow_skip_defines.svh"

module walu_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input walu_pkg::in_beat_t  in_beat_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input walu_pkg::out_beat_t out_beat_o
);
  import walu_pkg::*;

  logic        set_take;
  logic        set_out;
  logic        write_and_skip;
  logic [15:0] b_in;
  logic [15:0] res_a;

  // Short names for the terms that the properties below compare.
  assign set_take       = in_valid_i && in_ready_o && (in_beat_i.action == OP_SET);
  assign set_out        = out_valid_o && out_beat_o.write_a;
  assign write_and_skip = out_beat_o.write_a && (out_beat_o.skip_words != 2'd0);
  assign b_in           = in_beat_i.b_value;
  assign res_a          = out_beat_o.a_result;

  `WALU_ASSERT_NEXT(a_out_valid_holds, out_valid_o && !out_ready_i, out_valid_o)
  `WALU_ASSERT_IMPL(a_no_take_when_full, out_valid_o && !out_ready_i, !in_ready_o)
  `WALU_ASSERT_IMPL(a_write_or_skip, out_valid_o, !write_and_skip)
  `WALU_ASSERT_NEXT(a_set_next_cycle, set_take, set_out && (res_a == $past(b_in)))

endmodule

bind word_alu_with_overflow_skip walu_checker u_walu_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_beat_i   (in_beat_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_beat_o  (out_beat_o)
);

`default_nettype wire

// File: bench/word_alu_checker.sv
`timescale 1ns / 100ps
// Checker of the word ALU: predicts every output beat and compares it with the block.
module word_alu_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  walu_pkg::in_beat_t  in_beat_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  walu_pkg::out_beat_t out_beat_i,
  output int                  fail_count_o,
  output int                  pending_o
);
  import walu_pkg::*;

  logic [15:0] overflow_model;
  out_beat_t   awaited_beats[$];
  out_beat_t   predicted;
  out_beat_t   oldest;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  // An operand field costs an extra word for [next word] and [next word + reg]
  // as well as for the two literal next-word forms.
  function automatic logic [1:0] operand_word(input logic [5:0] field);
    return (field[5:4] == 2'b01 && (!field[3] || field[2:1] == 2'b11)) ? 2'd1 : 2'd0;
  endfunction

  function automatic out_beat_t execute_opcode(input in_beat_t beat, input logic [15:0] ovf);
    logic [15:0] a;
    logic [15:0] b;
    logic [31:0] wide;
    logic        test_failed;
    out_beat_t   res;
    a            = beat.a_value;
    b            = beat.b_value;
    res.a_result = a;
    res.write_a  = 1'b1;
    res.skip_words = 2'd0;
    test_failed  = 1'b0;
    case (beat.action)
      OP_SET: res.a_result = b;
      OP_ADD: begin
        wide         = {16'd0, a} + {16'd0, b};
        res.a_result = wide[15:0];
        ovf          = {15'd0, wide[16]};
      end
      OP_SUB: begin
        res.a_result = a - b;
        ovf          = (a < b) ? 16'hFFFF : 16'h0000;
      end
      OP_MUL: begin
        wide         = {16'd0, a} * {16'd0, b};
        res.a_result = wide[15:0];
        ovf          = wide[31:16];
      end
      OP_DIV: begin
        if (b != 16'd0) begin
          res.a_result = a / b;
          wide         = {a, 16'd0} / {16'd0, b};
          ovf          = wide[15:0];
        end else begin
          res.a_result = 16'd0;
          ovf          = 16'd0;
        end
      end
      OP_MOD: res.a_result = (b != 16'd0) ? a % b : 16'd0;
      OP_SHL: begin
        wide         = (b < 16'd32) ? ({16'd0, a} << b) : 32'd0;
        res.a_result = wide[15:0];
        ovf          = wide[31:16];
      end
      OP_SHR: begin
        wide         = (b < 16'd32) ? ({a, 16'd0} >> b) : 32'd0;
        res.a_result = wide[31:16];
        ovf          = wide[15:0];
      end
      OP_AND: res.a_result = a & b;
      OP_OR:  res.a_result = a | b;
      OP_XOR: res.a_result = a ^ b;
      OP_IFE: begin
        res.write_a = 1'b0;
        test_failed = (a != b);
      end
      OP_IFN: begin
        res.write_a = 1'b0;
        test_failed = (a == b);
      end
      OP_IFG: begin
        res.write_a = 1'b0;
        test_failed = (a <= b);
      end
      OP_IFB: begin
        res.write_a = 1'b0;
        test_failed = ((a & b) == 16'd0);
      end
      default: res.write_a = 1'b0;
    endcase
    if (test_failed) begin
      res.skip_words = 2'd1 + operand_word(beat.next_instruction[9:4])
                       + operand_word(beat.next_instruction[15:10]);
    end
    res.overflow_out = ovf;
    return res;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want_v,
                             input logic [15:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want_v, got_v);
      fail_count_o++;
    end
  endtask

  // Outputs are retired before the input of the same edge is predicted; an
  // output beat never belongs to an input accepted at the same edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      overflow_model = 16'd0;
      awaited_beats.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (awaited_beats.size() == 0) begin
          $display("%0t: unexpected output beat, expected none, actual %p", $time, out_beat_i);
          fail_count_o++;
        end else begin
          oldest = awaited_beats.pop_front();
          check_field("a_result", oldest.a_result, out_beat_i.a_result);
          check_field("write_a", oldest.write_a, out_beat_i.write_a);
          check_field("overflow_out", oldest.overflow_out, out_beat_i.overflow_out);
          check_field("skip_words", oldest.skip_words, out_beat_i.skip_words);
        end
      end
      if (in_valid_i && in_ready_i) begin
        predicted      = execute_opcode(in_beat_i, overflow_model);
        overflow_model = predicted.overflow_out;
        awaited_beats.push_back(predicted);
      end
    end
    pending_o = awaited_beats.size();
  end

endmodule

// File: bench/tb_word_alu_with_overflow_skip.sv
`timescale 1ns / 100ps
// Testbench top of the word ALU: clock, reset, stimulus, output stalls and the verdict.
module tb_word_alu_with_overflow_skip;
  import walu_pkg::*;

  // Number of random beats, and how many of the last ones run with no idling
  // on either side so that back-to-back traffic is exercised as well.
  localparam int RANDOM_BEATS = 550;
  localparam int QUIET_BEATS  = 60;
  // The slowest correct run is about 575 beats, each with the longest idle gap,
  // a divide and the longest output stall. The limit leaves a wide margin on
  // top of that.
  localparam int CYCLE_LIMIT  = 200000;
  // A divide is the longest operation: the full divider run plus the output register.
  localparam int DRAIN_CYCLES = 40;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_beat_t  in_beat;
  logic      out_valid;
  logic      out_ready;
  out_beat_t out_beat;

  int   fail_count;
  int   pending_count;
  int   cycle_count;
  int   stall_left;
  logic quiet_phase;

  word_alu_with_overflow_skip dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_beat_i  (in_beat),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_beat_o (out_beat)
  );

  word_alu_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_beat_i   (in_beat),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_beat_i  (out_beat),
    .fail_count_o(fail_count),
    .pending_o   (pending_count)
  );

  // Every input of the block and every piece of bench state is known from
  // time zero on.
  initial begin
    clk         = 1'b0;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_beat     = '0;
    out_ready   = 1'b0;
    cycle_count = 0;
    stall_left  = 0;
    quiet_phase = 1'b0;
  end

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watchdog: a hung handshake or a lost beat ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL word_alu_with_overflow_skip");
      $finish;
    end
  end

  // The receiver stalls in random bursts: ready drops low and stays low while
  // stall_left, drawn at the start of a burst, counts down to zero. Once the
  // quiet phase begins, ready stays high for good.
  always @(negedge clk) begin
    if (quiet_phase) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 11);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Sends one input beat. It is entered at a falling edge and returns at the
  // falling edge after the beat was taken, so the caller may drive the next
  // beat at once without touching valid twice in one time step. Before the
  // beat the sender may go quiet for a random burst, which lets gaps land on
  // any phase of a running divide.
  task automatic send_beat(input logic [3:0] op, input logic [15:0] a,
                           input logic [15:0] b, input logic [15:0] nxt);
    int gap;
    if (!quiet_phase && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_beat  <= '{action: op, a_value: a, b_value: b, next_instruction: nxt};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Operands lean toward the values where the arithmetic turns: zero, all
  // ones, small counts that matter for shifts, and single set bits.
  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(0, 40));
      3:       return 16'h8000 >> $urandom_range(0, 15);
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [3:0]  op;
    logic [15:0] a;
    logic [15:0] b;
    logic [15:0] nxt;
    int          n;

    // Reset is held low from time zero and released on a falling edge.
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed beats. The next-instruction word is laid out as b field,
    // a field, opcode: {6 bits, 6 bits, 4 bits}.
    send_beat(OP_NONBASIC, 16'h1234, 16'hABCD, 16'hFFFF);
    send_beat(OP_SET,      16'h0000, 16'hFFFF, 16'h0000);
    // Carry out of an add sets overflow to one, a plain add clears it.
    send_beat(OP_ADD,      16'hFFFF, 16'h0001, 16'h0000);
    send_beat(OP_ADD,      16'h0001, 16'h0002, 16'h0000);
    // Borrow on a subtract fills overflow with ones.
    send_beat(OP_SUB,      16'h0000, 16'h0001, 16'h0000);
    send_beat(OP_SUB,      16'h0005, 16'h0003, 16'h0000);
    send_beat(OP_MUL,      16'hFFFF, 16'hFFFF, 16'h0000);
    send_beat(OP_DIV,      16'hFFFF, 16'h0001, 16'h0000);
    // Divide by zero gives zero and clears overflow.
    send_beat(OP_DIV,      16'h1234, 16'h0000, 16'h0000);
    send_beat(OP_MUL,      16'h8000, 16'h0004, 16'h0000);
    // Modulo by zero gives zero and leaves overflow alone.
    send_beat(OP_MOD,      16'h1234, 16'h0000, 16'h0000);
    send_beat(OP_MOD,      16'hFFFF, 16'h0007, 16'h0000);
    send_beat(OP_SHL,      16'hFFFF, 16'd31,   16'h0000);
    // Shift amounts of 32 or more give zero in both directions.
    send_beat(OP_SHL,      16'hFFFF, 16'd32,   16'h0000);
    send_beat(OP_SHR,      16'hFFFF, 16'd1,    16'h0000);
    send_beat(OP_SHR,      16'hFFFF, 16'hFFFF, 16'h0000);
    send_beat(OP_AND,      16'hF0F0, 16'hFF00, 16'h0000);
    send_beat(OP_OR,       16'hF0F0, 16'h0F0F, 16'h0000);
    send_beat(OP_XOR,      16'hFFFF, 16'h5555, 16'h0000);
    // Failed tests skip one word plus one per next-word operand: both fields
    // read a literal next word here, so three words are skipped.
    send_beat(OP_IFE,      16'h0001, 16'h0002, {6'h1F, 6'h1E, 4'h1});
    send_beat(OP_IFE,      16'h7777, 16'h7777, {6'h1F, 6'h1E, 4'h1});
    // [next word] counts, [next word + reg] with bit 3 set does not.
    send_beat(OP_IFN,      16'hFFFF, 16'hFFFF, {6'h18, 6'h10, 4'h2});
    send_beat(OP_IFG,      16'h0000, 16'hFFFF, {6'h00, 6'h17, 4'h3});
    send_beat(OP_IFG,      16'hFFFF, 16'h0000, {6'h00, 6'h17, 4'h3});
    send_beat(OP_IFB,      16'hAAAA, 16'h5555, 16'h0000);

    // Random beats. Test operands are often made equal or disjoint so that
    // both outcomes of every test come up, and next-instruction fields are
    // often forced into the next-word range to reach every skip length.
    for (n = 0; n < RANDOM_BEATS; n++) begin
      if (n == RANDOM_BEATS - QUIET_BEATS) quiet_phase <= 1'b1;
      op  = 4'($urandom_range(0, 15));
      a   = pick_word();
      b   = pick_word();
      nxt = 16'($urandom);
      if ((op == OP_SHL || op == OP_SHR) && $urandom_range(0, 1) == 0) begin
        b = 16'($urandom_range(0, 40));
      end
      if (op >= OP_IFE) begin
        case ($urandom_range(0, 3))
          0:       b = a;
          1:       b = ~a;
          default: ;
        endcase
      end
      if ($urandom_range(0, 1) == 0) nxt[9:4] = {2'b01, 4'($urandom)};
      if ($urandom_range(0, 1) == 0) nxt[15:10] = {2'b01, 4'($urandom)};
      send_beat(op, a, b, nxt);
    end
    in_valid <= 1'b0;

    // Wait for every predicted beat to come out, then give a late or extra
    // beat time to show up before the verdict.
    while (pending_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("PASS word_alu_with_overflow_skip");
    end else begin
      $display("FAIL word_alu_with_overflow_skip");
    end
    $finish;
  end

endmodule

// File: word_alu_with_overflow_skip.f
+incdir+sv
sv/walu_pkg.sv
sv/walu_ctrl.sv
sv/walu_dp.sv
sv/word_alu_with_overflow_skip.sv
sv/walu_checker.sv
bench/word_alu_checker.sv
bench/tb_word_alu_with_overflow_skip.sv
